FILE: hw/rtl/dfcb_pkg.sv
// shared constants, codes and control structs for the cycle basis search
package dfcb_pkg;

  localparam int MAX_VERTICES_DEF = 8;
  localparam int MAX_RESULTS      = 21;
  localparam int NUM_VERT_RESET   = 8;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef struct packed {
    logic add_edge;
    logic clear_graph;
    logic run_init;
    logic scan;
    logic walk;
    logic emit;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic stack_empty;
    logic back_edge;
    logic walk_done;
    logic pend_valid;
    logic out_free;
    logic last_slot;
  } dp_status_t;

endpackage

FILE: hw/rtl/dfcb_if.sv
// handshake channel interfaces for command beats and result beats

interface dfcb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [2:0] vertex_a;
  logic [2:0] vertex_b;

  modport source (output valid, output func, output vertex_a, output vertex_b, input ready);
  modport sink   (input valid, input func, input vertex_a, input vertex_b, output ready);
endinterface

interface dfcb_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] cycle_number;
  logic [2:0] start_vertex;
  logic [2:0] end_vertex;
  logic [7:0] member_mask;
  logic       found;
  logic       last;

  modport source (output valid, output cycle_number, output start_vertex, output end_vertex,
                  output member_mask, output found, output last, input ready);
  modport sink   (input valid, input cycle_number, input start_vertex, input end_vertex,
                  input member_mask, input found, input last, output ready);
endinterface

FILE: hw/rtl/dfcb_ctrl.sv
// control state machine sequencing edge loads, search, parent walks and result beats
module dfcb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_func,
  output logic                in_ready,
  input  dfcb_pkg::dp_status_t st,
  output dfcb_pkg::dp_cmd_t    cmd
);
  import dfcb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_WALK = 5'b00100,
    S_EMIT = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (func_t'(in_func))
            FUNC_ADD:   cmd.add_edge = 1'b1;
            FUNC_CLEAR: cmd.clear_graph = 1'b1;
            FUNC_RUN: begin
              cmd.run_init = 1'b1;
              state_nxt    = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (st.stack_empty) begin
          state_nxt = S_FIN;
        end else begin
          cmd.scan = 1'b1;
          if (st.back_edge) state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (st.walk_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // held cycle moves out only when the output slot can take it
        if (!st.pend_valid || st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = st.last_slot ? S_FIN : S_SCAN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/dfcb_datapath.sv
// graph storage, search stack, parent walk and result registers
module dfcb_datapath #(
  parameter int MAX_VERTICES = dfcb_pkg::MAX_VERTICES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_wdata,
  input  logic [2:0]           in_vertex_a,
  input  logic [2:0]           in_vertex_b,
  input  dfcb_pkg::dp_cmd_t    cmd,
  output dfcb_pkg::dp_status_t st,
  dfcb_out_if.source           out_chan
);
  import dfcb_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [3:0]              nv_r;
  logic [MAX_VERTICES-1:0] adj_r  [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] exam_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] vis_r;
  logic [VW-1:0]           par_r  [MAX_VERTICES];
  logic [VW-1:0]           stk_v_r[MAX_VERTICES];
  logic [CW-1:0]           stk_n_r[MAX_VERTICES];
  logic [CW-1:0]           depth_r;
  logic [4:0]              cnt_r;
  logic [VW-1:0]           z_r;
  logic [VW-1:0]           wend_r;
  logic [CW-1:0]           steps_r;
  logic [MAX_VERTICES-1:0] wmask_r;

  logic                    pend_v_r;
  logic [4:0]              p_num_r;
  logic [2:0]              p_s_r;
  logic [2:0]              p_e_r;
  logic [7:0]              p_mask_r;

  logic                    o_valid_r;
  logic [4:0]              o_num_r;
  logic [2:0]              o_s_r;
  logic [2:0]              o_e_r;
  logic [7:0]              o_mask_r;
  logic                    o_found_r;
  logic                    o_last_r;

  logic [CW-1:0]           n_eff;
  logic [VW-1:0]           top;
  logic [VW-1:0]           cur;
  logic [CW-1:0]           y;
  logic [VW-1:0]           yi;
  logic                    in_range;
  logic                    edge_new;
  logic [VW-1:0]           va;
  logic [VW-1:0]           vb;
  logic                    add_ok;
  logic [VW-1:0]           zp;
  logic [MAX_VERTICES-1:0] cur_bit;
  logic [MAX_VERTICES-1:0] zp_bit;

  always_comb begin
    if (nv_r == 4'd0) begin
      n_eff = CW'(1);
    end else if (32'(nv_r) > MAX_VERTICES) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = CW'(nv_r);
    end
  end

  assign top      = VW'(depth_r - CW'(1));
  assign cur      = stk_v_r[top];
  assign y        = stk_n_r[top];
  assign in_range = (y < n_eff);
  assign yi       = VW'(y);
  assign edge_new = in_range && adj_r[cur][yi] && !exam_r[cur][yi];
  assign va       = VW'(in_vertex_a);
  assign vb       = VW'(in_vertex_b);
  assign add_ok   = (32'(in_vertex_a) < MAX_VERTICES) && (32'(in_vertex_b) < MAX_VERTICES);
  assign zp       = par_r[z_r];

  always_comb begin
    cur_bit      = '0;
    cur_bit[cur] = 1'b1;
    zp_bit       = '0;
    zp_bit[zp]   = 1'b1;
  end

  assign st.stack_empty = (depth_r == '0);
  assign st.back_edge   = edge_new && vis_r[yi];
  assign st.walk_done   = (z_r == wend_r) || !(steps_r < n_eff);
  assign st.pend_valid  = pend_v_r;
  assign st.out_free    = !o_valid_r || out_chan.ready;
  assign st.last_slot   = (cnt_r == 5'(MAX_RESULTS - 1));

  // configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r     <= 4'(NUM_VERT_RESET);
      vis_r    <= '0;
      depth_r  <= '0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        adj_r[i]  <= '0;
        exam_r[i] <= '0;
      end
    end else begin
      if (cfg_we) nv_r <= cfg_wdata;
      if (cmd.add_edge && add_ok) begin
        adj_r[va][vb] <= 1'b1;
        adj_r[vb][va] <= 1'b1;
      end
      if (cmd.clear_graph) begin
        for (int i = 0; i < MAX_VERTICES; i++) adj_r[i] <= '0;
      end
      if (cmd.run_init) begin
        for (int i = 0; i < MAX_VERTICES; i++) exam_r[i] <= '0;
        vis_r    <= MAX_VERTICES'(1);
        cnt_r    <= '0;
        depth_r  <= CW'(1);
        pend_v_r <= 1'b0;
      end
      if (cmd.scan) begin
        if (!in_range) begin
          depth_r <= depth_r - CW'(1);
        end else if (edge_new) begin
          exam_r[cur][yi] <= 1'b1;
          exam_r[yi][cur] <= 1'b1;
          if (!vis_r[yi]) begin
            vis_r[yi] <= 1'b1;
            if (32'(depth_r) < MAX_VERTICES) depth_r <= depth_r + CW'(1);
          end
        end
      end
      if (cmd.emit) begin
        pend_v_r <= 1'b1;
        cnt_r    <= cnt_r + 5'd1;
      end
      if (cmd.finish) pend_v_r <= 1'b0;
    end
  end

  // stack, parent links and walk registers
  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      par_r[0]   <= '0;
      stk_v_r[0] <= '0;
      stk_n_r[0] <= '0;
    end
    if (cmd.scan && in_range) begin
      stk_n_r[top] <= y + CW'(1);
      if (edge_new) begin
        if (!vis_r[yi]) begin
          par_r[yi] <= cur;
          if (32'(depth_r) < MAX_VERTICES) begin
            stk_v_r[VW'(depth_r)] <= yi;
            stk_n_r[VW'(depth_r)] <= '0;
          end
        end else begin
          // back edge: start walking parent links from the current vertex
          z_r     <= cur;
          wend_r  <= yi;
          steps_r <= '0;
          wmask_r <= cur_bit;
        end
      end
    end
    if (cmd.walk && !st.walk_done) begin
      z_r     <= zp;
      wmask_r <= wmask_r | zp_bit;
      steps_r <= steps_r + CW'(1);
    end
    if (cmd.emit) begin
      p_num_r  <= cnt_r;
      p_s_r    <= 3'(cur);
      p_e_r    <= 3'(wend_r);
      p_mask_r <= 8'(wmask_r);
    end
  end

  // output register: a held cycle leaves as non-last when a newer one arrives
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if ((cmd.emit && pend_v_r) || cmd.finish) begin
      o_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.emit && pend_v_r) || (cmd.finish && pend_v_r)) begin
      o_num_r   <= p_num_r;
      o_s_r     <= p_s_r;
      o_e_r     <= p_e_r;
      o_mask_r  <= p_mask_r;
      o_found_r <= 1'b1;
      o_last_r  <= cmd.finish;
    end else if (cmd.finish) begin
      o_num_r   <= '0;
      o_s_r     <= '0;
      o_e_r     <= '0;
      o_mask_r  <= '0;
      o_found_r <= 1'b0;
      o_last_r  <= 1'b1;
    end
  end

  assign out_chan.valid        = o_valid_r;
  assign out_chan.cycle_number = o_num_r;
  assign out_chan.start_vertex = o_s_r;
  assign out_chan.end_vertex   = o_e_r;
  assign out_chan.member_mask  = o_mask_r;
  assign out_chan.found        = o_found_r;
  assign out_chan.last         = o_last_r;

endmodule

FILE: hw/rtl/dfs_fundamental_cycle_basis_top.sv
// top level of the fundamental cycle basis search engine
//
//  channel   dir   beat contents
//  in_chan   in    func, vertex_a, vertex_b
//  out_chan  out   cycle_number, start_vertex, end_vertex, member_mask, found, last
//  cfg_*     in    num_vertices
//
// add and clear beats are taken while idle. a run takes a start step, then scans each
// adjacency bit of each pushed vertex and pops the vertex once its bits are done, and
// closes with a scan that finds the stack empty and a finish step. each cycle found adds
// a parent walk and an emit step, and a run stops at the cap of 21 found cycles.
// reset is synchronous and active low, and clears graph, marks and counters at once.
// a stalled result beat holds the search only when a second result needs the slot.
module dfs_fundamental_cycle_basis_top #(
  parameter int MAX_VERTICES = dfcb_pkg::MAX_VERTICES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  dfcb_in_if.sink    in_chan,
  dfcb_out_if.source out_chan
);
  import dfcb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  dfcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_func  (in_chan.func),
    .in_ready (in_chan.ready),
    .st       (st),
    .cmd      (cmd)
  );

  dfcb_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_vertex_a (in_chan.vertex_a),
    .in_vertex_b (in_chan.vertex_b),
    .cmd         (cmd),
    .st          (st),
    .out_chan    (out_chan)
  );

endmodule

FILE: hw/rtl/dfcb_checker.sv
// port-level checks on the cycle basis engine and their bind
module dfcb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] out_cycle_number,
  input logic [7:0] out_member_mask,
  input logic       out_found,
  input logic       out_last
);
  import dfcb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last)
    else $error("not-found beat without last");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_cycle_number == 5'd0 && out_member_mask == 8'd0)
    else $error("not-found beat carries data");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == FUNC_RUN |=> !in_ready)
    else $error("input taken right after run start");

endmodule

bind dfs_fundamental_cycle_basis_top dfcb_checker u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .in_func          (in_chan.func),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_cycle_number (out_chan.cycle_number),
  .out_member_mask  (out_chan.member_mask),
  .out_found        (out_chan.found),
  .out_last         (out_chan.last)
);

FILE: test/dfcb_test_if.sv
// testbench side of the channels: the interfaces come from the design sources
`timescale 1ns / 1ps

FILE: test/dfs_fundamental_cycle_basis_top_test.sv
// testbench for the fundamental cycle basis search: scoreboard with a dfs predictor
`timescale 1ns / 1ps

module dfs_fundamental_cycle_basis_top_test;
  import dfcb_pkg::*;

  localparam int NV = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [4:0] cycle_number;
    logic [2:0] start_vertex;
    logic [2:0] end_vertex;
    logic [7:0] member_mask;
    logic       found;
    logic       last;
  } cycle_res_t;

  class cycle_scoreboard;
    logic [7:0] adj [NV];
    logic [3:0] num_vertices;
    cycle_res_t pending_cycles [$];
    int errors;

    function void reset_graph();
      foreach (adj[i]) adj[i] = '0;
      num_vertices = 4'(NUM_VERT_RESET);
      pending_cycles.delete();
      errors = 0;
    endfunction

    function void predict_search();
      logic [7:0] seen [NV];
      logic [7:0] visited, mask;
      logic [2:0] parent [NV];
      logic [2:0] st_vert [NV];
      int st_next [NV];
      int n, depth, total, cur, y, z, steps;
      cycle_res_t r;
      n = num_vertices;
      if (n == 0) n = 1;
      if (n > NV) n = NV;
      foreach (seen[i]) begin
        seen[i] = '0;
        parent[i] = '0;
      end
      visited = 8'h01;
      total = 0;
      st_vert[0] = 0;
      st_next[0] = 0;
      depth = 1;
      while (depth > 0 && total < MAX_RESULTS) begin
        cur = st_vert[depth-1];
        y = st_next[depth-1];
        if (y >= n) begin
          depth--;
          continue;
        end
        st_next[depth-1] = y + 1;
        if (!adj[cur][y] || seen[cur][y]) continue;
        seen[cur][y] = 1'b1;
        seen[y][cur] = 1'b1;
        if (!visited[y]) begin
          visited[y] = 1'b1;
          parent[y] = 3'(cur);
          if (depth < NV) begin
            st_vert[depth] = 3'(y);
            st_next[depth] = 0;
            depth++;
          end
        end else begin
          z = cur;
          mask = 8'(1 << z);
          steps = 0;
          while (z != y && steps < n) begin
            z = parent[z];
            mask[z] = 1'b1;
            steps++;
          end
          r = '{5'(total), 3'(cur), 3'(y), mask, 1'b1, 1'b0};
          pending_cycles = {pending_cycles, r};
          total++;
        end
      end
      if (total == 0) begin
        r = '{5'd0, 3'd0, 3'd0, 8'd0, 1'b0, 1'b1};
        pending_cycles = {pending_cycles, r};
      end else begin
        pending_cycles[pending_cycles.size()-1].last = 1'b1;
      end
    endfunction

    function void note_command(logic [1:0] func, logic [2:0] a, logic [2:0] b);
      case (func_t'(func))
        FUNC_ADD: begin
          adj[a][b] = 1'b1;
          adj[b][a] = 1'b1;
        end
        FUNC_RUN: predict_search();
        FUNC_CLEAR: foreach (adj[i]) adj[i] = '0;
        default: ;
      endcase
    endfunction

    function void check_result(cycle_res_t got);
      cycle_res_t exp;
      if (pending_cycles.size() == 0) begin
        $error("unexpected result beat %p", got);
        errors++;
        return;
      end
      exp = pending_cycles.pop_front();
      if (got.cycle_number !== exp.cycle_number) begin
        $error("cycle_number: expected %0d, got %0d", exp.cycle_number, got.cycle_number);
        errors++;
      end
      if (got.start_vertex !== exp.start_vertex) begin
        $error("start_vertex: expected %0d, got %0d", exp.start_vertex, got.start_vertex);
        errors++;
      end
      if (got.end_vertex !== exp.end_vertex) begin
        $error("end_vertex: expected %0d, got %0d", exp.end_vertex, got.end_vertex);
        errors++;
      end
      if (got.member_mask !== exp.member_mask) begin
        $error("member_mask: expected %h, got %h", exp.member_mask, got.member_mask);
        errors++;
      end
      if (got.found !== exp.found) begin
        $error("found: expected %0d, got %0d", exp.found, got.found);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [3:0] cfg_wdata;
  bit calm_phase;
  int cycle_count;
  cycle_scoreboard sb;

  dfcb_in_if in_chan ();
  dfcb_out_if out_chan ();

  dfs_fundamental_cycle_basis_top #(.MAX_VERTICES(NV)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    sb = new();
    sb.reset_graph();
  end

  // result side: random stall bursts, check on accepted beats
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready)
        sb.check_result('{out_chan.cycle_number, out_chan.start_vertex, out_chan.end_vertex,
                          out_chan.member_mask, out_chan.found, out_chan.last});
      @(negedge clk);
      if (stall > 0) stall--;
      else if (!calm_phase && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 3);
      out_chan.ready = (stall == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_cmd(func_t func, logic [2:0] a, logic [2:0] b);
    int gap;
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.func <= func;
    in_chan.vertex_a <= a;
    in_chan.vertex_b <= b;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_command(func, a, b);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (sb.pending_cycles.size() != 0) @(negedge clk);
    // idle gap before the next command; the search is back in idle once its last beat is out
    repeat (150) @(negedge clk);
  endtask

  task automatic write_vertices(logic [3:0] n);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.num_vertices = n;
  endtask

  task automatic add_random_graph(int edges, int span);
    repeat (edges) send_cmd(FUNC_ADD, 3'($urandom_range(0, span)), 3'($urandom_range(0, span)));
  endtask

  initial begin
    int sel;
    cycle_count = 0;
    calm_phase = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.func = FUNC_NONE;
    in_chan.vertex_a = '0;
    in_chan.vertex_b = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty graph, self-loop, triangle, extremes, unused code
    send_cmd(FUNC_RUN, 3'd0, 3'd0);
    send_cmd(FUNC_ADD, 3'd0, 3'd0);
    send_cmd(FUNC_RUN, 3'd7, 3'd7);
    send_cmd(FUNC_ADD, 3'd0, 3'd1);
    send_cmd(FUNC_ADD, 3'd1, 3'd2);
    send_cmd(FUNC_ADD, 3'd2, 3'd0);
    send_cmd(FUNC_ADD, 3'd7, 3'd6);
    send_cmd(FUNC_NONE, 3'd5, 3'd3);
    send_cmd(FUNC_RUN, 3'd0, 3'd0);
    send_cmd(FUNC_CLEAR, 3'd7, 3'd7);
    send_cmd(FUNC_RUN, 3'd0, 3'd0);
    // complete graph on 8 with self-loops exceeds the cycle cap
    for (int i = 0; i < NV; i++)
      for (int j = i; j < NV; j++) send_cmd(FUNC_ADD, 3'(i), 3'(j));
    send_cmd(FUNC_RUN, 3'd0, 3'd0);
    write_vertices(4'd0);
    send_cmd(FUNC_RUN, 3'd0, 3'd0);
    write_vertices(4'd15);
    send_cmd(FUNC_RUN, 3'd0, 3'd0);
    write_vertices(4'd1);
    send_cmd(FUNC_RUN, 3'd0, 3'd0);
    write_vertices(4'd3);
    send_cmd(FUNC_RUN, 3'd0, 3'd0);
    send_cmd(FUNC_CLEAR, 3'd0, 3'd0);
    // sender holds off until everything is out
    drain_results();

    // random: mostly small graphs then a run, with some noise
    for (int k = 0; k < 5; k++) begin
      if (k % 4 == 3) write_vertices(4'($urandom_range(0, 15)));
      sel = $urandom_range(0, 9);
      if (sel < 2) send_cmd(FUNC_NONE, 3'($urandom), 3'($urandom));
      send_cmd(FUNC_CLEAR, 3'($urandom), 3'($urandom));
      add_random_graph($urandom_range(1, 8), (sel < 5) ? 4 : 7);
      send_cmd(FUNC_RUN, 3'($urandom), 3'($urandom));
      if (sel == 9) send_cmd(FUNC_RUN, 3'd0, 3'd0);
    end
    write_vertices(4'd8);
    calm_phase = 1'b1;
    for (int k = 0; k < 3; k++) begin
      send_cmd(FUNC_CLEAR, 3'd0, 3'd0);
      add_random_graph(6, 7);
      send_cmd(FUNC_RUN, 3'd0, 3'd0);
    end
    drain_results();

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
